// File: rtl/sle_pkg.sv
// sle_pkg: codes, characters and the result-group type of the serial line editor.
// No dependencies; imported by serial_line_editor_unit.
package sle_pkg;

  // operation codes
  localparam logic [1:0] OP_RX   = 2'd0;
  localparam logic [1:0] OP_TX   = 2'd1;
  localparam logic [1:0] OP_NL   = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_ECHO   = 1'b0;
  localparam logic REG_PROMPT = 1'b1;

  // characters
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_PROMPT  = 8'h3E;
  localparam logic [7:0] PRINT_FLOOR = 8'h19;

  localparam int MAX_RES = 4;

  // up to four results of one item
  typedef struct packed {
    logic [2:0]         n;
    logic [3:0][1:0]    k;
    logic [3:0][7:0]    b;
    logic [3:0]         e;
  } res_t;

  function automatic res_t res_add(res_t r, logic [1:0] k, logic [7:0] b, logic e);
    res_t o;
    o = r;
    if (r.n < 3'(MAX_RES)) begin
      o.k[r.n[1:0]] = k;
      o.b[r.n[1:0]] = b;
      o.e[r.n[1:0]] = e;
      o.n = r.n + 3'd1;
    end
    return o;
  endfunction

  // transmit one byte, LF expanded to CR LF and optional prompt
  function automatic res_t res_push_tx(res_t r, logic [7:0] ch, logic prompt);
    res_t o;
    o = r;
    if (ch == CH_LF) begin
      o = res_add(o, KIND_TX, CH_CR, 1'b0);
      o = res_add(o, KIND_TX, CH_LF, 1'b0);
      if (prompt) o = res_add(o, KIND_TX, CH_PROMPT, 1'b0);
    end else begin
      o = res_add(o, KIND_TX, ch, 1'b0);
    end
    return o;
  endfunction

endpackage

// File: rtl/serial_line_editor_unit.sv
// serial_line_editor_unit: terminal line editor with echo, line store and line reads.
// Depends on sle_pkg (codes, characters, result-group type and helpers).
//
// Usage
//   Input channel (in_valid/in_ready): one item = operation + data_byte.
//     OP_RX received byte, OP_TX byte to send, OP_NL ensure new line,
//     OP_READ pop one byte of a completed line.
//   Output channel (out_valid/out_ready): 0 to 4 result items per input item;
//     out_last marks the final one. Items with no result (silent receive,
//     redundant new line) produce nothing on this channel.
//   Config (APB, pready tied high): 0x0 echo_enable, 0x4 prompt_enable, bit 0.
// Timing
//   An item is taken into the decode stage; the line store read is launched
//   on the accept edge and its registered data is used in the decode stage,
//   where state is committed and the results load a 4-entry output buffer.
//   The first result is valid once the output buffer has been loaded.
//   An item commits only when the output buffer is empty or its last result
//   is being taken; the buffer drains one result per cycle while out_ready is high.
//   A new item is accepted in the same cycle the previous one commits; the
//   store address for it uses the post-commit indexes, and a same-entry write
//   in that cycle is forwarded.
// Reset: indexes, line count and new-line flag clear, line-start flag set, echo on,
//   prompt off; the line store valid bits clear at once so every entry reads as zero.
// Stall: while out_ready is low the buffer holds; one further item may wait
//   in the decode stage, after that in_ready drops.
module serial_line_editor_unit #(
  parameter int LINE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_end_of_line,
  output logic        out_last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sle_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  function automatic logic [AW-1:0] idx_next(logic [AW-1:0] i);
    return (i == AW'(LINE_DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(logic [AW-1:0] i);
    return (i == '0) ? AW'(LINE_DEPTH - 1) : i - AW'(1);
  endfunction

  // ---------------------------------------------------------------- config
  logic echo_r, prompt_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r   <= 1'b1;
      prompt_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ECHO:   echo_r   <= pwdata[0];
        REG_PROMPT: prompt_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ECHO:   prdata = {31'b0, echo_r};
      REG_PROMPT: prdata = {31'b0, prompt_r};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  logic [AW-1:0] wi_r, wi_nxt;
  logic [AW-1:0] ri_r, ri_nxt;
  logic [7:0]    lines_r, lines_nxt;
  logic          als_r, als_nxt;     // reader at line start
  logic          nlf_r, nlf_nxt;     // last thing sent ended a line

  // decode stage
  logic          s1_vld_r;
  logic [1:0]    s1_op_r;
  logic [7:0]    s1_ch_r;
  logic          s1_go;

  // output buffer
  res_t          obuf_r;
  logic [2:0]    rem_r;
  logic [1:0]    head_r;
  logic          buf_free;
  logic          out_pop;

  // line store
  logic [7:0]            mem [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] vld_r;
  logic [AW-1:0]         raddr;
  logic [7:0]            rd_data_r;
  logic                  rd_vld_r;
  logic                  fwd_r;
  logic [7:0]            fwd_data_r;
  logic [7:0]            s1_data;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  res_t          res;

  logic in_acc;

  assign out_pop  = out_valid & out_ready;
  assign buf_free = (rem_r == 3'd0) || (rem_r == 3'd1 && out_ready);
  assign s1_go    = s1_vld_r & buf_free;
  assign in_ready = ~s1_vld_r | s1_go;
  assign in_acc   = in_valid & in_ready;

  // forwarded store data for the item in decode
  assign s1_data = fwd_r ? fwd_data_r : (rd_vld_r ? rd_data_r : 8'h00);

  // commit logic of the item in decode
  always_comb begin
    logic [AW-1:0] wi_c, ri_c;
    logic [7:0]    lines_c;
    logic          als_c, nlf_c;
    res   = '0;
    wi_c  = wi_r;
    ri_c  = ri_r;
    lines_c = lines_r;
    als_c = als_r;
    nlf_c = nlf_r;
    we    = 1'b0;
    waddr = wi_r;
    wdata = 8'h00;
    case (s1_op_r)
      OP_RX: begin
        if (echo_r) begin
          res   = res_push_tx(res, s1_ch_r, prompt_r);
          nlf_c = (s1_ch_r == CH_LF);
        end
        if (s1_ch_r == CH_CR) begin
          // terminator stored; the CR is echoed, then CR LF
          we      = 1'b1;
          wi_c    = idx_next(wi_r);
          lines_c = lines_r + 8'd1;
          if (echo_r) begin
            res   = res_push_tx(res, CH_LF, prompt_r);
            nlf_c = 1'b1;
          end
        end
        if (s1_ch_r == CH_BS && s1_data != 8'h00) begin
          // rub out previous stored byte
          we    = 1'b1;
          waddr = idx_prev(wi_r);
          wi_c  = idx_prev(wi_r);
          if (echo_r) begin
            res   = res_push_tx(res, CH_SP, prompt_r);
            res   = res_push_tx(res, CH_BS, prompt_r);
            nlf_c = 1'b0;
          end
        end
        if (s1_ch_r > PRINT_FLOOR) begin
          we    = 1'b1;
          wdata = s1_ch_r;
          wi_c  = idx_next(wi_r);
        end
      end
      OP_TX: begin
        res   = res_push_tx(res, s1_ch_r, prompt_r);
        nlf_c = (s1_ch_r == CH_LF);
      end
      OP_NL: begin
        if (!nlf_r) begin
          res   = res_push_tx(res, CH_LF, prompt_r);
          nlf_c = 1'b1;
        end
      end
      default: begin // OP_READ
        if (als_r && lines_r == 8'd0) begin
          res = res_add(res, KIND_NONE, 8'h00, 1'b0);
        end else begin
          ri_c = idx_next(ri_r);
          if (als_r) begin
            lines_c = lines_r - 8'd1;
            if (s1_data == 8'h00) begin
              // empty line reads as CR then terminator
              res = res_add(res, KIND_LINE, CH_CR, 1'b0);
              res = res_add(res, KIND_LINE, 8'h00, 1'b1);
            end else begin
              res   = res_add(res, KIND_LINE, s1_data, 1'b0);
              als_c = 1'b0;
            end
          end else if (s1_data == 8'h00) begin
            res   = res_add(res, KIND_LINE, 8'h00, 1'b1);
            als_c = 1'b1;
          end else begin
            res = res_add(res, KIND_LINE, s1_data, 1'b0);
          end
        end
      end
    endcase
    wi_nxt    = s1_go ? wi_c    : wi_r;
    ri_nxt    = s1_go ? ri_c    : ri_r;
    lines_nxt = s1_go ? lines_c : lines_r;
    als_nxt   = s1_go ? als_c   : als_r;
    nlf_nxt   = s1_go ? nlf_c   : nlf_r;
    we        = we & s1_go;
  end

  // store address for the item being accepted, from post-commit indexes
  assign raddr = (in_operation == OP_RX && in_data_byte == CH_BS) ? idx_prev(wi_nxt) : ri_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r    <= '0;
      ri_r    <= '0;
      lines_r <= '0;
      als_r   <= 1'b1;
      nlf_r   <= 1'b0;
    end else begin
      wi_r    <= wi_nxt;
      ri_r    <= ri_nxt;
      lines_r <= lines_nxt;
      als_r   <= als_nxt;
      nlf_r   <= nlf_nxt;
    end
  end

  // line store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (in_acc) begin
      rd_data_r  <= mem[raddr];
      fwd_data_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      if (in_acc) begin
        rd_vld_r <= vld_r[raddr];
        fwd_r    <= we && (waddr == raddr);
      end
    end
  end

  // decode stage
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (in_ready) s1_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= in_operation;
      s1_ch_r <= in_data_byte;
    end
  end

  // output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      head_r <= '0;
    end else if (s1_go && res.n != 3'd0) begin
      rem_r  <= res.n;
      head_r <= '0;
    end else if (out_pop) begin
      rem_r  <= rem_r - 3'd1;
      head_r <= head_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.n != 3'd0) obuf_r <= res;
  end

  assign out_valid       = (rem_r != 3'd0);
  assign out_kind        = obuf_r.k[head_r];
  assign out_byte        = obuf_r.b[head_r];
  assign out_end_of_line = obuf_r.e[head_r];
  assign out_last        = (rem_r == 3'd1);

  // ---------------------------------------------------------------- checks
  a_eol_is_terminator: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_line |-> out_byte == 8'h00 && out_kind == KIND_LINE)
    else $error("end of line on a non-terminator result");

  a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NONE |-> out_last && head_r == 2'd0)
    else $error("no-line result not alone in its group");

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({2'b00, head_r} + {1'b0, rem_r}) <= 4'd4)
    else $error("output buffer overrun");

  a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_go |=> $stable(rd_data_r) && $stable(fwd_r) && $stable(s1_op_r))
    else $error("store read data lost while decode stage stalled");

endmodule
